// ----- hw/rtl/gconn_pkg.sv -----
`timescale 1ns / 1ps

package gconn_pkg;

	localparam int CMP_W = 9;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int VCOUNT_W = 6;
	localparam int VERTEX_W = 5;

	localparam logic [PADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;
	localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RESET = 6'd32;

	typedef enum logic [1:0] {
		REQ_ADD   = 2'd0,
		REQ_QUERY = 2'd1,
		REQ_CLEAR = 2'd2
	} req_type_t;

	typedef struct packed {
		logic clear;
		logic add;
		logic start;
		logic step;
	} cell_ctrl_t;

	typedef struct packed {
		logic all_reached;
		logic any_change;
	} link_t;

endpackage

// ----- hw/rtl/gconn_req_if.sv -----
`timescale 1ns / 1ps

interface gconn_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       req_type;
	logic [gconn_pkg::VERTEX_W-1:0]   vertex_a;
	logic [gconn_pkg::VERTEX_W-1:0]   vertex_b;

	modport source (output valid, output req_type, output vertex_a, output vertex_b, input ready);
	modport sink (input valid, input req_type, input vertex_a, input vertex_b, output ready);
endinterface

// ----- hw/rtl/gconn_res_if.sv -----
`timescale 1ns / 1ps

interface gconn_res_if;
	logic valid;
	logic ready;
	logic connected;

	modport source (output valid, output connected, input ready);
	modport sink (input valid, input connected, output ready);
endinterface

// ----- hw/rtl/gconn_cell.sv -----
`timescale 1ns / 1ps

module gconn_cell #(
	parameter int MAX_VERTICES = 32,
	parameter int INDEX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gconn_pkg::cell_ctrl_t     ctrl,
	input  logic                      in_use,
	input  logic [MAX_VERTICES-1:0]   mask_a,
	input  logic [MAX_VERTICES-1:0]   mask_b,
	input  logic [MAX_VERTICES-1:0]   visited_vec,
	input  gconn_pkg::link_t          link_in,
	output logic                      visited,
	output gconn_pkg::link_t          link_out
);

	logic [MAX_VERTICES-1:0] row_q;
	logic                    visited_q;
	logic                    vis_next;

	always_comb begin
		vis_next = in_use & (visited_q | (|(row_q & visited_vec)));
		link_out.all_reached = link_in.all_reached & (visited_q | ~in_use);
		link_out.any_change = link_in.any_change | (vis_next != visited_q);
	end

	assign visited = visited_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			visited_q <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				row_q <= '0;
			end else if (ctrl.add) begin
				row_q <= row_q | (mask_a[INDEX] ? mask_b : '0) | (mask_b[INDEX] ? mask_a : '0);
			end
			if (ctrl.start) begin
				visited_q <= 1'(INDEX == 0);
			end else if (ctrl.step) begin
				visited_q <= vis_next;
			end
		end
	end

endmodule

// ----- hw/rtl/graph_connectivity_check_unit.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Beat fields                          Handshake
// req       in   req_type, vertex_a, vertex_b         valid/ready
// res       out  connected                            valid/ready
// apb       in   vertex_count at offset 0             psel/penable/pready
//
// Add and clear beats are taken one per cycle while no query is in progress.
// A query floods reachability from vertex 0 through the cell chain, one hop per cycle,
// and the search ends once a step changes no visited bit, so its length is set by
// the longest shortest path from vertex 0; a graph of at most one vertex skips it.
// Reset clears the adjacency rows and the visited bits at once; no sweep follows.
// A result waiting in the output register does not stop add and clear beats, but a
// finished query holds the request channel until the previous result beat is taken.

module graph_connectivity_check_unit #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [gconn_pkg::PADDR_W-1:0]      paddr,
	input  logic [gconn_pkg::PDATA_W-1:0]      pwdata,
	output logic [gconn_pkg::PDATA_W-1:0]      prdata,
	output logic                               pready,
	gconn_req_if.sink                          req,
	gconn_res_if.source                        res
);

	localparam int CmpW = gconn_pkg::CMP_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_FLUSH
	} state_t;

	state_t                              state_q;
	logic [gconn_pkg::VCOUNT_W-1:0]      vertex_count_q;
	logic                                res_valid_q;
	logic                                res_conn_q;
	logic                                conn_pend_q;

	logic                                req_fire;
	logic                                small_graph;
	logic                                edge_ok;
	gconn_pkg::cell_ctrl_t               ctrl;
	logic [MAX_VERTICES-1:0]             in_use;
	logic [MAX_VERTICES-1:0]             mask_a;
	logic [MAX_VERTICES-1:0]             mask_b;
	logic [MAX_VERTICES-1:0]             visited;
	gconn_pkg::link_t                    link_w [MAX_VERTICES+1];

	assign pready = 1'b1;
	assign prdata = (paddr == gconn_pkg::ADDR_VERTEX_COUNT) ?
		{{(gconn_pkg::PDATA_W-gconn_pkg::VCOUNT_W){1'b0}}, vertex_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= gconn_pkg::VERTEX_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr == gconn_pkg::ADDR_VERTEX_COUNT) begin
			vertex_count_q <= pwdata[gconn_pkg::VCOUNT_W-1:0];
		end
	end

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire = req.valid && req.ready;
	assign small_graph = (vertex_count_q <= gconn_pkg::VCOUNT_W'(1));
	assign edge_ok = (CmpW'(req.vertex_a) < CmpW'(vertex_count_q))
		&& (CmpW'(req.vertex_a) < CmpW'(MAX_VERTICES))
		&& (CmpW'(req.vertex_b) < CmpW'(vertex_count_q))
		&& (CmpW'(req.vertex_b) < CmpW'(MAX_VERTICES));

	always_comb begin
		ctrl.clear = req_fire && req.req_type == gconn_pkg::REQ_CLEAR;
		ctrl.add = req_fire && req.req_type == gconn_pkg::REQ_ADD && edge_ok;
		ctrl.start = req_fire && req.req_type == gconn_pkg::REQ_QUERY && !small_graph;
		ctrl.step = (state_q == ST_SEARCH);
	end

	always_comb begin
		for (int j = 0; j < MAX_VERTICES; j++) begin
			in_use[j] = CmpW'(j) < CmpW'(vertex_count_q);
			mask_a[j] = CmpW'(j) == CmpW'(req.vertex_a);
			mask_b[j] = CmpW'(j) == CmpW'(req.vertex_b);
		end
	end

	assign link_w[0] = '{all_reached: 1'b1, any_change: 1'b0};

	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
		gconn_cell #(
			.MAX_VERTICES(MAX_VERTICES),
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.in_use(in_use[i]),
			.mask_a(mask_a),
			.mask_b(mask_b),
			.visited_vec(visited),
			.link_in(link_w[i]),
			.visited(visited[i]),
			.link_out(link_w[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			res_valid_q <= 1'b0;
			res_conn_q <= 1'b0;
			conn_pend_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready && state_q != ST_FLUSH) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire && req.req_type == gconn_pkg::REQ_QUERY) begin
						if (small_graph) begin
							conn_pend_q <= 1'b1;
							state_q <= ST_FLUSH;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (!link_w[MAX_VERTICES].any_change) begin
						conn_pend_q <= link_w[MAX_VERTICES].all_reached;
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_conn_q <= conn_pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res.valid = res_valid_q;
	assign res.connected = res_conn_q;

	// The search root stays marked for the whole walk.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> visited[0])
		else $error("root vertex lost its visited mark during a search");

	// Vertices outside the active count are never marked.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SEARCH |-> (visited & ~in_use) == '0)
		else $error("vertex outside the active count was marked");

	// A query on a graph of at most one vertex goes straight to the output stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.req_type == gconn_pkg::REQ_QUERY && small_graph)
		|=> (state_q == ST_FLUSH && conn_pend_q))
		else $error("trivial query did not resolve as connected");

	// Leaving the output stage always loads a result beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && (!res_valid_q || res.ready)) |=> res_valid_q)
		else $error("result beat was not loaded");

endmodule

// ----- dv/gconn_connectivity_checker.sv -----
`timescale 1ns / 1ps

module gconn_connectivity_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [gconn_pkg::PADDR_W-1:0]  paddr,
	input  logic [gconn_pkg::PDATA_W-1:0]  pwdata,
	input  logic [gconn_pkg::PDATA_W-1:0]  prdata,
	input  logic                           pready,
	gconn_req_if                           req,
	gconn_res_if                           res,
	output int                             mismatches,
	output int                             results_owed
);

	localparam int NV = 32;

	logic [NV-1:0]                  adj [NV];
	logic [gconn_pkg::VCOUNT_W-1:0] vcount;
	bit                             connected_due [$];

	function automatic int vertices_in_use();
		return (int'(vcount) > NV) ? NV : int'(vcount);
	endfunction

	// Flood reachability from vertex 0, one hop per round, over the vertices in use.
	function automatic bit graph_is_connected();
		logic [NV-1:0] mask;
		logic [NV-1:0] seen;
		logic [NV-1:0] grow;
		int            n;
		n = vertices_in_use();
		if (n <= 1)
			return 1'b1;
		mask = (n >= NV) ? '1 : ((32'd1 << n) - 32'd1);
		seen = 32'd1;
		for (int k = 0; k < n; k++) begin
			grow = seen;
			for (int u = 0; u < NV; u++) begin
				if (seen[u])
					grow = grow | (adj[u] & mask);
			end
			seen = grow;
		end
		return seen == mask;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bit want;
		if (!arst_n) begin
			for (int r = 0; r < NV; r++)
				adj[r] = '0;
			vcount = gconn_pkg::VERTEX_COUNT_RESET;
			connected_due.delete();
			mismatches = 0;
		end else begin
			if (psel && penable && pready && paddr == gconn_pkg::ADDR_VERTEX_COUNT) begin
				if (pwrite) begin
					vcount = pwdata[gconn_pkg::VCOUNT_W-1:0];
				end else if (prdata !== gconn_pkg::PDATA_W'(vcount)) begin
					mismatches++;
					$display("%0t: vertex_count read expected %0d, actual %0d",
						$time, vcount, prdata);
				end
			end
			if (req.valid && req.ready) begin
				case (req.req_type)
					gconn_pkg::REQ_ADD: begin
						if (int'(req.vertex_a) < vertices_in_use() &&
							int'(req.vertex_b) < vertices_in_use()) begin
							adj[req.vertex_a][req.vertex_b] = 1'b1;
							adj[req.vertex_b][req.vertex_a] = 1'b1;
						end
					end
					gconn_pkg::REQ_QUERY: begin
						connected_due.push_back(graph_is_connected());
					end
					gconn_pkg::REQ_CLEAR: begin
						for (int r = 0; r < NV; r++)
							adj[r] = '0;
					end
					default: begin
					end
				endcase
			end
			if (res.valid && res.ready) begin
				if (connected_due.size() == 0) begin
					mismatches++;
					$display("%0t: connected expected none, actual %0b", $time, res.connected);
				end else begin
					want = connected_due.pop_front();
					if (res.connected !== want) begin
						mismatches++;
						$display("%0t: connected expected %0b, actual %0b",
							$time, want, res.connected);
					end
				end
			end
		end
		results_owed = connected_due.size();
	end

endmodule

// ----- dv/tb_graph_connectivity_check_unit.sv -----
`timescale 1ns / 1ps

module tb_graph_connectivity_check_unit;

	localparam int CLK_PERIOD = 20;
	localparam int ITEMS = 900;
	localparam int QUERY_DRAIN = 40;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [gconn_pkg::PADDR_W-1:0] paddr;
	logic [gconn_pkg::PDATA_W-1:0] pwdata;
	logic [gconn_pkg::PDATA_W-1:0] prdata;
	logic pready;

	int mismatches;
	int results_owed;
	int idle_odds = 4;
	int beats_sent = 0;

	gconn_req_if req_ch ();
	gconn_res_if res_ch ();

	graph_connectivity_check_unit #(
		.MAX_VERTICES(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.res(res_ch)
	);

	gconn_connectivity_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req(req_ch),
		.res(res_ch),
		.mismatches(mismatches),
		.results_owed(results_owed)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		#(CLK_PERIOD * 400000);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 4)) @(negedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_beat(input logic [1:0] kind, input logic [gconn_pkg::VERTEX_W-1:0] a,
		input logic [gconn_pkg::VERTEX_W-1:0] b);
		if (beats_sent >= ITEMS - 150)
			idle_odds = 0;
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.vertex_a <= a;
		req_ch.vertex_b <= b;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
		if (kind != REQ_UNUSED)
			beats_sent++;
	endtask

	task automatic send_noise();
		int r;
		logic [1:0] kind;
		r = $urandom_range(0, 15);
		if (r == 0)
			kind = gconn_pkg::REQ_CLEAR;
		else if (r <= 2)
			kind = REQ_UNUSED;
		else if (r <= 4)
			kind = gconn_pkg::REQ_QUERY;
		else
			kind = gconn_pkg::REQ_ADD;
		send_beat(kind, gconn_pkg::VERTEX_W'($urandom), gconn_pkg::VERTEX_W'($urandom));
	endtask

	task automatic settle();
		req_ch.valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (QUERY_DRAIN) @(negedge clk);
	endtask

	task automatic set_vertex_count(input logic [gconn_pkg::VCOUNT_W-1:0] count);
		logic [gconn_pkg::PDATA_W-1:0] word;
		settle();
		word = $urandom_range(0, 1) ? gconn_pkg::PDATA_W'($urandom) : '0;
		word[gconn_pkg::VCOUNT_W-1:0] = count;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= gconn_pkg::ADDR_VERTEX_COUNT;
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Builds a shuffled spanning tree over the vertices in use, sometimes with a
	// missing branch, with queries and stray beats mixed in.
	task automatic grow_graph(input int n);
		logic [gconn_pkg::VERTEX_W-1:0] order [32];
		logic [gconn_pkg::VERTEX_W-1:0] swap;
		logic [gconn_pkg::VERTEX_W-1:0] other;
		int pick;
		int drop_odds;
		for (int i = 0; i < 32; i++)
			order[i] = gconn_pkg::VERTEX_W'(i);
		for (int i = n - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			swap = order[i];
			order[i] = order[pick];
			order[pick] = swap;
		end
		drop_odds = $urandom_range(0, 1) ? 0 : $urandom_range(4, 10);
		if ($urandom_range(0, 5) != 0)
			send_beat(gconn_pkg::REQ_CLEAR, gconn_pkg::VERTEX_W'($urandom),
				gconn_pkg::VERTEX_W'($urandom));
		for (int i = 1; i < n; i++) begin
			other = order[$urandom_range(0, i - 1)];
			if (drop_odds == 0 || $urandom_range(1, drop_odds) != 1) begin
				if ($urandom_range(0, 1))
					send_beat(gconn_pkg::REQ_ADD, order[i], other);
				else
					send_beat(gconn_pkg::REQ_ADD, other, order[i]);
			end
			if ($urandom_range(0, 4) == 0)
				send_beat(gconn_pkg::REQ_QUERY, gconn_pkg::VERTEX_W'($urandom),
					gconn_pkg::VERTEX_W'($urandom));
			if ($urandom_range(0, 7) == 0)
				send_noise();
		end
		send_beat(gconn_pkg::REQ_QUERY, gconn_pkg::VERTEX_W'($urandom),
			gconn_pkg::VERTEX_W'($urandom));
	endtask

	initial begin
		logic [gconn_pkg::VCOUNT_W-1:0] count;
		int phase;
		int r;
		int reps;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = gconn_pkg::REQ_ADD;
		req_ch.vertex_a = '0;
		req_ch.vertex_b = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_vertex_count(6'd32);
		send_beat(gconn_pkg::REQ_QUERY, 5'd31, 5'd31);
		send_beat(gconn_pkg::REQ_ADD, 5'd0, 5'd31);
		send_beat(gconn_pkg::REQ_ADD, 5'd31, 5'd31);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		send_beat(REQ_UNUSED, 5'd31, 5'd31);
		send_beat(gconn_pkg::REQ_CLEAR, 5'd0, 5'd0);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		set_vertex_count(6'd0);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		send_beat(gconn_pkg::REQ_ADD, 5'd0, 5'd0);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		set_vertex_count(6'd1);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		send_beat(gconn_pkg::REQ_ADD, 5'd0, 5'd1);
		set_vertex_count(6'd2);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		send_beat(gconn_pkg::REQ_ADD, 5'd1, 5'd0);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		set_vertex_count(6'd63);
		send_beat(gconn_pkg::REQ_ADD, 5'd31, 5'd30);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);
		set_vertex_count(6'd3);
		send_beat(gconn_pkg::REQ_ADD, 5'd2, 5'd5);
		send_beat(gconn_pkg::REQ_ADD, 5'd2, 5'd1);
		send_beat(gconn_pkg::REQ_QUERY, 5'd0, 5'd0);

		phase = 0;
		while (beats_sent < ITEMS) begin
			case (phase)
				0: count = 6'd32;
				1: count = 6'd0;
				2: count = 6'd63;
				3: count = 6'd1;
				4: count = 6'd2;
				5: count = 6'd33;
				default: begin
					r = $urandom_range(0, 9);
					if (r < 6)
						count = gconn_pkg::VCOUNT_W'($urandom_range(2, 12));
					else if (r < 8)
						count = gconn_pkg::VCOUNT_W'($urandom_range(13, 32));
					else if (r == 8)
						count = 6'd32;
					else
						count = gconn_pkg::VCOUNT_W'($urandom_range(33, 63));
				end
			endcase
			set_vertex_count(count);
			if (beats_sent >= ITEMS - 150)
				idle_odds = 0;
			else
				idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 8);
			reps = $urandom_range(2, 4);
			for (int k = 0; k < reps && beats_sent < ITEMS; k++)
				grow_graph((int'(count) > 32) ? 32 : int'(count));
			phase++;
		end

		req_ch.valid <= 1'b0;
		while (results_owed != 0) @(negedge clk);
		repeat (QUERY_DRAIN) @(negedge clk);
		if (mismatches == 0 && results_owed == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
